[rtl/nearest_brightness_glyph_search_unit_defines.svh]
// assertion macros shared by the glyph search rtl
`ifndef NEAREST_BRIGHTNESS_GLYPH_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_BRIGHTNESS_GLYPH_SEARCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NBGS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nbgs: same-cycle check failed");
`define NBGS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nbgs: next-cycle check failed");
`else
`define NBGS_ASSERT_IMPL(label, ante, cons)
`define NBGS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/nbgs_pkg.sv]
// shared constants, opcodes and controller/datapath interface types
package nbgs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CODE_W      = 21;
  localparam int LUM_W       = 16;

  localparam logic [CODE_W-1:0] SPACE_CODE = CODE_W'(32);
  localparam logic [LUM_W-1:0]  FULL_SCALE = {LUM_W{1'b1}};

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  // commands from controller to datapath
  typedef struct packed {
    logic query_load;
    logic append;
    logic clear;
    logic search_step;
    logic pick_load;
    logic cur_hold;
    logic decide;
    logic result_load;
  } nbgs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic search_last;
  } nbgs_sts_t;

endpackage

[rtl/nearest_brightness_glyph_search_unit.sv]
// top level of the nearest brightness glyph search unit
// An item is taken when start is high and busy is low. Append and clear items
// take effect at that edge and the unit is ready again in the next cycle; an
// append to a full table is dropped. A query bisects a table of the running
// maximum brightness, one memory read and one compare per step, then reads the
// found entry and the one before it, picks the closer and reads its glyph code.
// A query on an empty table skips the search. The result shows on glyph_code,
// score, loss and table_empty for exactly one cycle with done high, in the cycle
// where busy falls; it must be taken then, as the unit has no way to hold it.
module nearest_brightness_glyph_search_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [nbgs_pkg::CODE_W-1:0]   entry_code,
  input  logic [nbgs_pkg::LUM_W-1:0]    entry_brightness,
  input  logic [nbgs_pkg::LUM_W-1:0]    luminance,
  output logic                          done,
  output logic [nbgs_pkg::CODE_W-1:0]   glyph_code,
  output logic [nbgs_pkg::LUM_W-1:0]    score,
  output logic [nbgs_pkg::LUM_W-1:0]    loss,
  output logic                          table_empty
);
  import nbgs_pkg::*;

  nbgs_cmd_t cmd;
  nbgs_sts_t sts;

  // sequencing
  nbgs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // table and search datapath
  nbgs_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .entry_code       (entry_code),
    .entry_brightness (entry_brightness),
    .luminance        (luminance),
    .glyph_code       (glyph_code),
    .score            (score),
    .loss             (loss),
    .table_empty      (table_empty)
  );

endmodule

[rtl/nbgs_ctrl.sv]
// sequencing state machine for append, clear and query items
`include "nearest_brightness_glyph_search_unit_defines.svh"
module nbgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  nbgs_pkg::nbgs_sts_t sts,
  output nbgs_pkg::nbgs_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import nbgs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RD_CUR,
    S_RD_PREV,
    S_DECIDE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_QUERY: begin
              cmd.query_load = 1'b1;
              state_next     = sts.count_zero ? S_FINISH : S_SRCH_RD;
            end
            OP_APPEND: cmd.append = 1'b1;
            OP_CLEAR:  cmd.clear  = 1'b1;
            default: ;
          endcase
        end
      end
      S_SRCH_RD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        cmd.search_step = 1'b1;
        state_next      = sts.search_last ? S_RD_CUR : S_SRCH_RD;
      end
      S_RD_CUR: begin
        cmd.pick_load = 1'b1;
        state_next    = S_RD_PREV;
      end
      S_RD_PREV: begin
        cmd.cur_hold = 1'b1;
        state_next   = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.result_load = 1'b1;
        state_next      = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
    end
  end

  `NBGS_ASSERT_IMPL(a_done_idle, done, !busy)
  `NBGS_ASSERT_IMPL(a_done_after_finish, done, $past(state) == S_FINISH)
  `NBGS_ASSERT_NEXT(a_query_busy, start && !busy && (opcode == OP_QUERY), busy)

endmodule

[rtl/nbgs_dpath.sv]
// glyph table memories, bisection registers and result registers
`include "nearest_brightness_glyph_search_unit_defines.svh"
module nbgs_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  nbgs_pkg::nbgs_cmd_t           cmd,
  output nbgs_pkg::nbgs_sts_t           sts,
  input  logic [nbgs_pkg::CODE_W-1:0]   entry_code,
  input  logic [nbgs_pkg::LUM_W-1:0]    entry_brightness,
  input  logic [nbgs_pkg::LUM_W-1:0]    luminance,
  output logic [nbgs_pkg::CODE_W-1:0]   glyph_code,
  output logic [nbgs_pkg::LUM_W-1:0]    score,
  output logic [nbgs_pkg::LUM_W-1:0]    loss,
  output logic                          table_empty
);
  import nbgs_pkg::*;

  function automatic logic [LUM_W-1:0] abs_diff(input logic [LUM_W-1:0] a,
                                                input logic [LUM_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // table stores: brightness, running maximum of brightness, glyph code
  logic [LUM_W-1:0]  bright_mem [TABLE_DEPTH];
  logic [LUM_W-1:0]  pmax_mem   [TABLE_DEPTH];
  logic [CODE_W-1:0] code_mem   [TABLE_DEPTH];

  logic [CNT_W-1:0]  count;
  logic [LUM_W-1:0]  run_max;
  logic [LUM_W-1:0]  new_max;
  logic              full;

  logic [LUM_W-1:0]  lum_r;
  logic              empty_r;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;
  logic              ge;
  logic [CNT_W-1:0]  lo_next;
  logic [CNT_W-1:0]  hi_next;

  logic [CNT_W-1:0]  pick_cnt;
  logic [ADDR_W-1:0] pick_first;
  logic [ADDR_W-1:0] pick;
  logic [ADDR_W-1:0] bright_addr;
  logic [LUM_W-1:0]  pmax_rd;
  logic [LUM_W-1:0]  bright_rd;
  logic [CODE_W-1:0] code_rd;
  logic [LUM_W-1:0]  cur_b;
  logic [LUM_W-1:0]  d_cur;
  logic [LUM_W-1:0]  d_prev;
  logic              prev_closer;
  logic [ADDR_W-1:0] final_pick;
  logic [LUM_W-1:0]  loss_r;

  assign full    = (count == CNT_W'(TABLE_DEPTH));
  assign new_max = ((count == '0) || (entry_brightness > run_max)) ? entry_brightness : run_max;

  // bisection step over the running maximum: first entry not below luminance
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign ge      = (pmax_rd >= lum_r);
  assign lo_next = ge ? lo : mid + CNT_W'(1);
  assign hi_next = ge ? mid : hi;

  assign sts.count_zero  = (count == '0);
  assign sts.search_last = (lo_next >= hi_next);

  // no entry found: fall back to the last one
  assign pick_cnt   = (lo == count) ? count - CNT_W'(1) : lo;
  assign pick_first = pick_cnt[ADDR_W-1:0];
  assign bright_addr = cmd.pick_load ? pick_first : pick - ADDR_W'(1);

  // neighbour compare, earlier entry only when strictly closer
  assign d_cur       = abs_diff(cur_b, lum_r);
  assign d_prev      = abs_diff(bright_rd, lum_r);
  assign prev_closer = (pick != '0) && (d_prev < d_cur);
  assign final_pick  = prev_closer ? pick - ADDR_W'(1) : pick;

  // table writes on append
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      bright_mem[count[ADDR_W-1:0]] <= entry_brightness;
      pmax_mem[count[ADDR_W-1:0]]   <= new_max;
      code_mem[count[ADDR_W-1:0]]   <= entry_code;
    end
  end

  // registered table reads
  always_ff @(posedge clk) begin
    pmax_rd   <= pmax_mem[mid[ADDR_W-1:0]];
    bright_rd <= bright_mem[bright_addr];
    code_rd   <= code_mem[final_pick];
  end

  // fill count and search bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      lo    <= '0;
      hi    <= '0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.query_load) begin
        lo <= '0;
        hi <= count;
      end else if (cmd.search_step) begin
        lo <= lo_next;
        hi <= hi_next;
      end
    end
  end

  // running maximum and query payload
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      run_max <= new_max;
    end
    if (cmd.query_load) begin
      lum_r   <= luminance;
      empty_r <= (count == '0);
    end
    if (cmd.pick_load) begin
      pick <= pick_first;
    end
    if (cmd.cur_hold) begin
      cur_b <= bright_rd;
    end
    if (cmd.decide) begin
      loss_r <= prev_closer ? d_prev : d_cur;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      if (empty_r) begin
        glyph_code  <= SPACE_CODE;
        score       <= '0;
        loss        <= FULL_SCALE;
        table_empty <= 1'b1;
      end else begin
        glyph_code  <= code_rd;
        score       <= FULL_SCALE - loss_r;
        loss        <= loss_r;
        table_empty <= 1'b0;
      end
    end
  end

  `NBGS_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(TABLE_DEPTH))
  `NBGS_ASSERT_IMPL(a_bounds_order, 1'b1, (lo <= hi) && (hi <= CNT_W'(TABLE_DEPTH)))
  `NBGS_ASSERT_NEXT(a_empty_result, cmd.result_load && empty_r, (glyph_code == SPACE_CODE) && table_empty)

endmodule

[tb/nearest_brightness_glyph_search_unit_test.sv]
// self-checking testbench for the nearest brightness glyph search unit
module nearest_brightness_glyph_search_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nbgs_pkg::*;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned CODE_MAX      = 1114111;
  localparam int unsigned LUM_MAX       = 65535;
  localparam int          RANDOM_ITEMS  = 300;
  localparam int          DRAIN_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 30;

  // one query result as the unit reports it
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LUM_W-1:0]  score;
    logic [LUM_W-1:0]  loss;
    logic              empty;
  } glyph_match_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        opcode;
  logic [CODE_W-1:0] entry_code;
  logic [LUM_W-1:0]  entry_brightness;
  logic [LUM_W-1:0]  luminance;
  logic              done;
  logic [CODE_W-1:0] glyph_code;
  logic [LUM_W-1:0]  score;
  logic [LUM_W-1:0]  loss;
  logic              table_empty;

  // predicted glyph table
  logic [CODE_W-1:0] table_codes [TABLE_DEPTH];
  logic [LUM_W-1:0]  table_bright [TABLE_DEPTH];
  int                table_count;

  // query results still owed by the unit, oldest first
  glyph_match_t      pending_matches [$];

  bit                gap_free;
  int                error_count;
  int                query_count;
  int                append_count;
  int                dropped_count;
  int                clear_count;
  int                unused_count;
  int                matched_count;

  nearest_brightness_glyph_search_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .entry_code       (entry_code),
    .entry_brightness (entry_brightness),
    .luminance        (luminance),
    .done             (done),
    .glyph_code       (glyph_code),
    .score            (score),
    .loss             (loss),
    .table_empty      (table_empty)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // distance between two brightness values
  function automatic logic [LUM_W-1:0] lum_distance(input logic [LUM_W-1:0] a,
                                                    input logic [LUM_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // first entry not below the luminance, else the last, then the closer neighbour
  function automatic glyph_match_t nearest_glyph(input logic [LUM_W-1:0] lum);
    glyph_match_t m;
    int           pick;
    int           i;
    m.code  = SPACE_CODE;
    m.score = '0;
    m.loss  = FULL_SCALE;
    m.empty = 1'b1;
    if (table_count == 0) return m;
    pick = table_count - 1;
    for (i = 0; i < table_count; i++) begin
      if (table_bright[i] >= lum) begin
        pick = i;
        break;
      end
    end
    if (pick > 0 &&
        lum_distance(table_bright[pick-1], lum) < lum_distance(table_bright[pick], lum))
      pick--;
    m.code  = table_codes[pick];
    m.loss  = lum_distance(table_bright[pick], lum);
    m.score = FULL_SCALE - m.loss;
    m.empty = 1'b0;
    return m;
  endfunction

  // random hold-off after an accepted item
  task automatic idle_gap();
    int r;
    int cycles;
    r = $urandom_range(0, 99);
    if (gap_free || r < 55) cycles = 0;
    else if (r < 90) cycles = $urandom_range(1, 3);
    else cycles = $urandom_range(8, 40);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // present one item, wait for its accept and update the predicted table
  task automatic send_item(input logic [1:0]        op,
                           input logic [CODE_W-1:0] code,
                           input logic [LUM_W-1:0]  bright,
                           input logic [LUM_W-1:0]  lum);
    start            <= 1'b1;
    opcode           <= op;
    entry_code       <= code;
    entry_brightness <= bright;
    luminance        <= lum;
    do @(posedge clk); while (busy !== 1'b0);
    case (op)
      OP_QUERY: begin
        pending_matches.push_back(nearest_glyph(lum));
        query_count++;
      end
      OP_APPEND: begin
        append_count++;
        if (table_count < TABLE_DEPTH) begin
          table_codes[table_count]  = code;
          table_bright[table_count] = bright;
          table_count++;
        end else begin
          dropped_count++;
        end
      end
      OP_CLEAR: begin
        table_count = 0;
        clear_count++;
      end
      default: unused_count++;
    endcase
    idle_gap();
  endtask

  // unused fields carry random values so every bit toggles
  task automatic send_query(input logic [LUM_W-1:0] lum);
    send_item(OP_QUERY, CODE_W'($urandom_range(0, CODE_MAX)),
              LUM_W'($urandom_range(0, LUM_MAX)), lum);
  endtask

  task automatic send_append(input logic [CODE_W-1:0] code, input logic [LUM_W-1:0] bright);
    send_item(OP_APPEND, code, bright, LUM_W'($urandom_range(0, LUM_MAX)));
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, CODE_W'($urandom_range(0, CODE_MAX)),
              LUM_W'($urandom_range(0, LUM_MAX)), LUM_W'($urandom_range(0, LUM_MAX)));
  endtask

  // luminance aimed at interesting spots of the current table
  function automatic logic [LUM_W-1:0] pick_luminance();
    int r;
    int j;
    int v;
    r = $urandom_range(0, 99);
    if (r < 70 && r >= 30 && table_count > 0) begin
      j = $urandom_range(0, table_count - 1);
      v = int'(table_bright[j]) + $urandom_range(0, 2) - 1;
      if (v < 0) v = 0;
      if (v > LUM_MAX) v = LUM_MAX;
      return LUM_W'(v);
    end
    if (r < 90 && r >= 70 && table_count > 1) begin
      // midpoint of two neighbours, an exact tie when their gap is even
      j = $urandom_range(1, table_count - 1);
      return LUM_W'((int'(table_bright[j-1]) + int'(table_bright[j]) +
                     $urandom_range(0, 1)) / 2);
    end
    if (r >= 95) return ($urandom_range(0, 1) != 0) ? LUM_W'(LUM_MAX) : '0;
    return LUM_W'($urandom_range(0, LUM_MAX));
  endfunction

  task automatic check_field(input string name, input logic [CODE_W-1:0] want,
                             input logic [CODE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // compare each result with the oldest outstanding query
  always @(posedge clk) begin : check_results
    glyph_match_t want;
    if (!rst && done === 1'b1) begin
      if (pending_matches.size() == 0) begin
        $error("result with no query outstanding: glyph_code %0d", glyph_code);
        error_count++;
      end else begin
        want = pending_matches.pop_front();
        matched_count++;
        check_field("glyph_code", want.code, glyph_code);
        check_field("score", CODE_W'(want.score), CODE_W'(score));
        check_field("loss", CODE_W'(want.loss), CODE_W'(loss));
        check_field("table_empty", CODE_W'(want.empty), CODE_W'(table_empty));
      end
    end
  end

  // queries and a meaningless opcode on a table that was never filled
  task automatic test_empty_table();
    send_query(0);
    send_item(OP_UNUSED, CODE_W'($urandom_range(0, CODE_MAX)),
              LUM_W'($urandom_range(0, LUM_MAX)), LUM_W'($urandom_range(0, LUM_MAX)));
    send_query(LUM_W'(LUM_MAX));
  endtask

  // extremes, ties, duplicates, out-of-order appends and clearing
  task automatic test_edge_cases();
    send_clear();
    send_append(0, 0);
    send_append(CODE_W'(CODE_MAX), LUM_W'(LUM_MAX));
    send_query(0);
    send_query(LUM_W'(LUM_MAX));
    send_query(32767);
    send_query(32768);
    send_clear();
    send_append('h41, 1000);
    send_append('h42, 1000);
    send_append('h43, 3000);
    send_query(2000);
    send_query(1000);
    send_query(999);
    send_query(LUM_W'(LUM_MAX));
    // entry below its predecessor
    send_append('h44, 500);
    send_query(400);
    send_query(3500);
    send_item(OP_UNUSED, CODE_W'(CODE_MAX), LUM_W'(LUM_MAX), LUM_W'(LUM_MAX));
    send_clear();
    send_query(12345);
  endtask

  // fill every entry, then appends to a full table are dropped
  task automatic test_full_table();
    int i;
    send_clear();
    for (i = 0; i < TABLE_DEPTH; i++)
      send_append(CODE_W'((i == TABLE_DEPTH - 1) ? CODE_MAX : $urandom_range(0, CODE_MAX)),
                  LUM_W'(i * 256 + $urandom_range(0, 255)));
    repeat (3) send_append(CODE_W'($urandom_range(0, CODE_MAX)),
                           LUM_W'($urandom_range(0, LUM_MAX)));
    send_query(0);
    send_query(LUM_W'(LUM_MAX));
    repeat (8) send_query(pick_luminance());
    send_clear();
    send_query(LUM_W'($urandom_range(0, LUM_MAX)));
  endtask

  // mostly sorted tables with queries, with some noise in between
  task automatic test_random_sequences();
    int sent;
    int k;
    int span;
    int b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gap_free = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 3) != 0 || table_count > 200) begin
          send_clear();
          sent++;
        end
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
        span = 65536 / (k + 1);
        b = (table_count == 0) ? int'($urandom_range(0, span))
                               : int'(table_bright[table_count-1]);
        repeat (k) begin
          // some duplicates of the previous brightness
          if ($urandom_range(0, 4) != 0) b += $urandom_range(1, span);
          if (b > LUM_MAX) b = LUM_MAX;
          send_append(CODE_W'($urandom_range(0, CODE_MAX)), LUM_W'(b));
          sent++;
        end
        repeat ($urandom_range(1, 8)) begin
          send_query(pick_luminance());
          sent++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: send_item(OP_UNUSED, CODE_W'($urandom_range(0, CODE_MAX)),
                       LUM_W'($urandom_range(0, LUM_MAX)),
                       LUM_W'($urandom_range(0, LUM_MAX)));
          1: send_append(CODE_W'($urandom_range(0, CODE_MAX)),
                         LUM_W'($urandom_range(0, LUM_MAX)));
          2: send_query(LUM_W'($urandom_range(0, LUM_MAX)));
          default: send_clear();
        endcase
        sent++;
      end
    end
    gap_free = 1'b0;
  endtask

  // test sequence
  initial begin : run_tests
    int waited;
    rst              = 1'b1;
    start            = 1'b0;
    opcode           = OP_QUERY;
    entry_code       = '0;
    entry_brightness = '0;
    luminance        = '0;
    table_count      = 0;
    gap_free         = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_edge_cases();
    test_full_table();
    test_random_sequences();
    start <= 1'b0;

    // drain outstanding results, then let the unit settle
    waited = 0;
    while (pending_matches.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_matches.size() != 0) begin
      $error("%0d query results never arrived", pending_matches.size());
      error_count++;
    end

    $display("covered %0d queries, %0d appends (%0d dropped on a full table), %0d clears",
             query_count, append_count, dropped_count, clear_count);
    $display("and %0d items with an unused opcode; %0d results compared, %0d errors",
             unused_count, matched_count, error_count);
    if (error_count == 0) begin
      $display("nearest_brightness_glyph_search_unit_test passed");
    end else begin
      $display("nearest_brightness_glyph_search_unit_test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("nearest_brightness_glyph_search_unit_test failed");
    $finish;
  end

endmodule
